FILE: sv/voice_activity_hysteresis_debounce_fade_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef VOICE_ACTIVITY_HYSTERESIS_DEBOUNCE_FADE_DEFINES_SVH
`define VOICE_ACTIVITY_HYSTERESIS_DEBOUNCE_FADE_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define VAHDF_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// condition must never be seen outside reset
`define VAHDF_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define VAHDF_ASSERT(lbl, clk, rst, prop)
`define VAHDF_NEVER(lbl, clk, rst, cond)
`endif

`endif

FILE: sv/vahdf_pkg.sv
// ---------------------------------------------------------------------------
// vahdf_pkg
// Shared types and constants of the voice activity debounce/fade block.
// ---------------------------------------------------------------------------
package vahdf_pkg;

  localparam logic [16:0] FULL_SCALE = 17'h10000;

  localparam logic [15:0] RST_THRESHOLD_ON  = 16'd9830;
  localparam logic [15:0] RST_THRESHOLD_OFF = 16'd6554;
  localparam logic [15:0] RST_SWITCH_DELAY  = 16'd50;
  localparam logic [16:0] RST_FADE_STEP     = 17'd6991;

  typedef enum logic [2:0] {
    IDX_THRESHOLD_ON  = 3'd0,
    IDX_THRESHOLD_OFF = 3'd1,
    IDX_SWITCH_DELAY  = 3'd2,
    IDX_FADE_STEP     = 3'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] threshold_on;
    logic [15:0] threshold_off;
    logic [15:0] switch_delay_ms;
    logic [16:0] fade_step;
  } cfg_t;

  typedef struct packed {
    logic        talk_shown;
    logic [16:0] fade_progress;
    logic        fade_active;
  } res_t;

endpackage

FILE: sv/vahdf_cfg.sv
// ---------------------------------------------------------------------------
// vahdf_cfg
// Configuration register file, write only.
// ---------------------------------------------------------------------------
module vahdf_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [16:0]         cfg_data,
  output vahdf_pkg::cfg_t     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_on    <= vahdf_pkg::RST_THRESHOLD_ON;
      cfg.threshold_off   <= vahdf_pkg::RST_THRESHOLD_OFF;
      cfg.switch_delay_ms <= vahdf_pkg::RST_SWITCH_DELAY;
      cfg.fade_step       <= vahdf_pkg::RST_FADE_STEP;
    end else if (cfg_we) begin
      case (vahdf_pkg::cfg_idx_t'(cfg_index))
        vahdf_pkg::IDX_THRESHOLD_ON:  cfg.threshold_on    <= cfg_data[15:0];
        vahdf_pkg::IDX_THRESHOLD_OFF: cfg.threshold_off   <= cfg_data[15:0];
        vahdf_pkg::IDX_SWITCH_DELAY:  cfg.switch_delay_ms <= cfg_data[15:0];
        vahdf_pkg::IDX_FADE_STEP:     cfg.fade_step       <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/vahdf_core.sv
// ---------------------------------------------------------------------------
// vahdf_core
// Hysteresis compare, debounce timer and fade progress, one word per load.
// ---------------------------------------------------------------------------
`include "voice_activity_hysteresis_debounce_fade_defines.svh"

module vahdf_core (
  input  logic                clk,
  input  logic                rst,
  input  vahdf_pkg::cfg_t     cfg,
  input  logic                load,
  input  logic [15:0]         peak_level,
  input  logic [31:0]         now_ms,
  output vahdf_pkg::res_t     res
);

  logic        talk_state;
  logic        change_pending;
  logic [31:0] change_start;
  logic [16:0] progress;

  logic        talk_state_next;
  logic        change_pending_next;
  logic [31:0] change_start_next;
  logic [16:0] progress_next;

  logic        wanted;
  logic        differs;
  logic [31:0] start_eff;
  logic [31:0] elapsed;
  logic        commit;
  logic [16:0] base;
  logic [17:0] sum;
  logic        advance;

  always_comb begin
    wanted = talk_state;
    if (!talk_state && peak_level >= cfg.threshold_on) begin
      wanted = 1'b1;
    end else if (talk_state && peak_level <= cfg.threshold_off) begin
      wanted = 1'b0;
    end
    differs   = wanted != talk_state;
    // a fresh change starts timing at this tick
    start_eff = change_pending ? change_start : now_ms;
    elapsed   = now_ms - start_eff;
    commit    = differs && (elapsed >= {16'd0, cfg.switch_delay_ms});

    talk_state_next     = commit ? wanted : talk_state;
    change_pending_next = differs && !commit;
    change_start_next   = start_eff;

    base    = commit ? 17'd0 : progress;
    sum     = {1'b0, base} + {1'b0, cfg.fade_step};
    advance = (cfg.fade_step != 17'd0) && (base < vahdf_pkg::FULL_SCALE);
    if (!advance) begin
      progress_next = base;
    end else if (sum > {1'b0, vahdf_pkg::FULL_SCALE}) begin
      progress_next = vahdf_pkg::FULL_SCALE;
    end else begin
      progress_next = sum[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      talk_state     <= 1'b0;
      change_pending <= 1'b0;
      change_start   <= 32'd0;
      progress       <= 17'd0;
    end else if (load) begin
      talk_state     <= talk_state_next;
      change_pending <= change_pending_next;
      change_start   <= change_start_next;
      progress       <= progress_next;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (load) begin
      res.talk_shown    <= talk_state_next;
      res.fade_progress <= progress_next;
      res.fade_active   <= (cfg.fade_step != 17'd0) &&
                           (progress_next < vahdf_pkg::FULL_SCALE);
    end
  end

  `VAHDF_NEVER(a_progress_range, clk, rst, progress > vahdf_pkg::FULL_SCALE)
  `VAHDF_ASSERT(a_talk_holds, clk, rst, !load |=> $stable(talk_state))
  `VAHDF_ASSERT(a_commit_clears, clk, rst, (load && commit) |=> !change_pending)

endmodule

FILE: sv/voice_activity_hysteresis_debounce_fade.sv
// ---------------------------------------------------------------------------
// voice_activity_hysteresis_debounce_fade
// Talk/idle detector with hysteresis, debounce delay and crossfade progress.
// ---------------------------------------------------------------------------
//  port group  dir  handshake                  payload
//  in          in   in_valid / in_stall        peak_level, now_ms
//  out         out  out_valid / out_stall      talk_shown, fade_progress,
//                                              fade_active
//  cfg         in   cfg_we                     cfg_index, cfg_data
//
//  One word per cycle sustained while out_stall is low.
//  Input register feeds the core, whose state and result register load together.
//  out_stall holds the result word; the input register keeps taking a word
//  while it is empty or the result register is free or being drained.
//  Synchronous reset restores register defaults and idle state, progress zero.
// ---------------------------------------------------------------------------
module voice_activity_hysteresis_debounce_fade (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] peak_level,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        talk_shown,
  output logic [16:0] fade_progress,
  output logic        fade_active,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  vahdf_pkg::cfg_t cfg;
  vahdf_pkg::res_t res;

  logic        s1_valid;
  logic [15:0] s1_peak;
  logic [31:0] s1_now;
  logic        s1_move;
  logic        in_take;

  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_peak <= peak_level;
      s1_now  <= now_ms;
    end
  end

  vahdf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  vahdf_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .load       (s1_move),
    .peak_level (s1_peak),
    .now_ms     (s1_now),
    .res        (res)
  );

  assign talk_shown    = res.talk_shown;
  assign fade_progress = res.fade_progress;
  assign fade_active   = res.fade_active;

endmodule

FILE: tb/sv/tb_voice_activity_hysteresis_debounce_fade.sv
// ---------------------------------------------------------------------------
// tb_voice_activity_hysteresis_debounce_fade
// Self-checking bench for the talk/idle detector. A cycle-level predictor
// follows every accepted input word and queues the result word it should
// produce. The bench runs directed hysteresis, debounce and fade cases, then
// random bursts of loud and quiet levels under several register settings and
// idle/stall mixes, then a long output hold-off that backs up the pipeline.
// ---------------------------------------------------------------------------
module tb_voice_activity_hysteresis_debounce_fade;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LATENCY_PAD = 6;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned REPORT_MAX  = 10;
  // first index past the register file
  localparam logic [2:0]  IDX_UNMAPPED = 3'(vahdf_pkg::IDX_FADE_STEP) + 3'd1;

  typedef enum {LVL_LOUD, LVL_QUIET, LVL_NEAR_ON, LVL_NEAR_OFF, LVL_ANY} level_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] peak_level = '0;
  logic [31:0] now_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        talk_shown;
  logic [16:0] fade_progress;
  logic        fade_active;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  // predictor state and its copy of the registers
  logic        vad_talk;
  logic        vad_armed;
  logic [31:0] vad_armed_at;
  logic [16:0] vad_fade;
  logic [15:0] vad_on;
  logic [15:0] vad_off;
  logic [15:0] vad_delay;
  logic [16:0] vad_step;

  vahdf_pkg::res_t tick_results[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_start = 1'b0;
  int unsigned hold_left = 0;

  voice_activity_hysteresis_debounce_fade i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .peak_level    (peak_level),
    .now_ms        (now_ms),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .talk_shown    (talk_shown),
    .fade_progress (fade_progress),
    .fade_active   (fade_active),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one tick of the detector: hysteresis, debounce, then fade advance
  function automatic vahdf_pkg::res_t detector_tick(input logic [15:0] lvl,
                                                    input logic [31:0] stamp);
    logic            want;
    logic [17:0]     sum;
    vahdf_pkg::res_t r;
    want = vad_talk;
    if (!vad_talk && lvl >= vad_on) begin
      want = 1'b1;
    end else if (vad_talk && lvl <= vad_off) begin
      want = 1'b0;
    end
    if (want != vad_talk) begin
      if (!vad_armed) begin
        vad_armed    = 1'b1;
        vad_armed_at = stamp;
      end
      if (32'(stamp - vad_armed_at) >= {16'd0, vad_delay}) begin
        vad_talk  = want;
        vad_armed = 1'b0;
        vad_fade  = '0;
      end
    end else begin
      vad_armed = 1'b0;
    end
    if (vad_step != '0 && vad_fade < vahdf_pkg::FULL_SCALE) begin
      sum = {1'b0, vad_fade} + {1'b0, vad_step};
      vad_fade = (sum > {1'b0, vahdf_pkg::FULL_SCALE}) ? vahdf_pkg::FULL_SCALE : sum[16:0];
    end
    r.talk_shown    = vad_talk;
    r.fade_progress = vad_fade;
    r.fade_active   = (vad_step != '0 && vad_fade < vahdf_pkg::FULL_SCALE);
    return r;
  endfunction

  // result check, then prediction for the accepted word, then register writes
  always @(posedge clk) begin
    vahdf_pkg::res_t want;
    if (rst) begin
      vad_talk     = 1'b0;
      vad_armed    = 1'b0;
      vad_armed_at = '0;
      vad_fade     = '0;
      vad_on       = vahdf_pkg::RST_THRESHOLD_ON;
      vad_off      = vahdf_pkg::RST_THRESHOLD_OFF;
      vad_delay    = vahdf_pkg::RST_SWITCH_DELAY;
      vad_step     = vahdf_pkg::RST_FADE_STEP;
      tick_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (tick_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("unexpected result word: talk=%0d prog=%0d act=%0d",
                     talk_shown, fade_progress, fade_active);
        end else begin
          want = tick_results.pop_front();
          if (talk_shown !== want.talk_shown || fade_progress !== want.fade_progress ||
              fade_active !== want.fade_active) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
              $display("mismatch: exp talk=%0d prog=%0d act=%0d, got talk=%0d prog=%0d act=%0d",
                       want.talk_shown, want.fade_progress, want.fade_active,
                       talk_shown, fade_progress, fade_active);
          end
        end
      end
      if (in_valid && !in_stall)
        tick_results.push_back(detector_tick(peak_level, now_ms));
      if (cfg_we) begin
        case (cfg_index)
          vahdf_pkg::IDX_THRESHOLD_ON:  vad_on    = cfg_data[15:0];
          vahdf_pkg::IDX_THRESHOLD_OFF: vad_off   = cfg_data[15:0];
          vahdf_pkg::IDX_SWITCH_DELAY:  vad_delay = cfg_data[15:0];
          vahdf_pkg::IDX_FADE_STEP:     vad_step  = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // receiver: random stall, or a counted hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_start) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_voice_activity_hysteresis_debounce_fade: done, errors");
      $finish;
    end
  end

  // offers one word, with a random gap first, and returns at its acceptance edge
  task automatic send_tick(input logic [15:0] lvl, input logic [31:0] stamp);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    peak_level <= lvl;
    now_ms     <= stamp;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tick_results.size() != 0) @(posedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // 16-bit registers get a random bit 16, which must be dropped
  task automatic load_config(input logic [15:0] th_on, input logic [15:0] th_off,
                             input logic [15:0] dly, input logic [16:0] step);
    write_reg(vahdf_pkg::IDX_THRESHOLD_ON,  {1'($urandom_range(1)), th_on});
    write_reg(vahdf_pkg::IDX_THRESHOLD_OFF, {1'($urandom_range(1)), th_off});
    write_reg(vahdf_pkg::IDX_SWITCH_DELAY,  {1'($urandom_range(1)), dly});
    write_reg(vahdf_pkg::IDX_FADE_STEP,     step);
    cfg_we <= 1'b0;
  endtask

  // reset settings: threshold edges, debounce timing, wrap and backwards time
  task automatic test_directed_levels();
    send_tick(16'd0,     32'd0);
    send_tick(16'hFFFF,  32'd0);          // change armed at time zero
    send_tick(16'd9830,  32'd49);         // one short of the delay
    send_tick(16'd9830,  32'd50);         // commit to talking
    send_tick(16'd9829,  32'd60);
    send_tick(16'd6555,  32'd70);
    send_tick(16'd6554,  32'd80);         // off threshold reached, armed
    send_tick(16'd20000, 32'd90);         // back to talking level, pending dropped
    send_tick(16'd0,     32'd100);
    send_tick(16'd0,     32'd99);         // time went backwards, commits at once
    send_tick(16'hFFFF,  32'hFFFF_FFF0);
    send_tick(16'hFFFF,  32'h0000_0022);  // wrapped difference equals the delay
    send_tick(16'h8000,  32'hAAAA_AAAA);
    send_tick(16'h0000,  32'h5555_5555);
    send_tick(16'h0000,  32'h5555_5587);
    for (int i = 0; i < 6; i++)
      send_tick(16'h0001, 32'h5555_5600 + i);  // fade advances towards full scale
    drain_results();
  endtask

  // zero delay, fade disabled, oversized steps, unmapped register index
  task automatic test_special_settings();
    load_config(16'd9830, 16'd6554, 16'd0, 17'd0);
    send_tick(16'hFFFF, 32'd1000);
    send_tick(16'h0000, 32'd1000);
    send_tick(16'hFFFF, 32'd1001);
    drain_results();
    load_config(16'd9830, 16'd6554, 16'd0, 17'h1FFFF);
    send_tick(16'h0000, 32'd2000);
    send_tick(16'h0000, 32'd2001);
    drain_results();
    load_config(16'd9830, 16'd6554, 16'd0, vahdf_pkg::FULL_SCALE);
    send_tick(16'hFFFF, 32'd3000);
    send_tick(16'hFFFF, 32'd3001);
    drain_results();
    write_reg(IDX_UNMAPPED + 3'($urandom_range(3)), 17'($urandom()));
    cfg_we <= 1'b0;
    send_tick(16'h0000, 32'd4000);
    drain_results();
  endtask

  // bursts on either side of the thresholds under several settings and idle mixes
  task automatic test_random_traffic();
    int unsigned on_tab[8]    = '{9830, 0,     65535, 40000, 20000, 1000,  0, 9830};
    int unsigned off_tab[8]   = '{6554, 65535, 0,     30000, 20000, 60000, 0, 6554};
    int unsigned dly_tab[8]   = '{50,   0,     65535, 10,    3,     7,     0, 150};
    int unsigned step_tab[8]  = '{6991, 65536, 0,     1,     131071, 4096, 0, 1092};
    int unsigned send_tab[4]  = '{0, 62, 0, 36};
    int unsigned stall_tab[4] = '{0, 0, 62, 36};
    int unsigned th_on, th_off, dly, step, r, run_left;
    level_kind_t kind;
    logic [15:0] lvl;
    logic [31:0] stamp;
    stamp    = 32'hFFFF_F000;
    run_left = 0;
    kind     = LVL_ANY;
    for (int seg = 0; seg < 8; seg++) begin
      th_on  = on_tab[seg];
      th_off = off_tab[seg];
      dly    = dly_tab[seg];
      step   = step_tab[seg];
      if (seg == 6) begin
        th_on  = $urandom_range(65535);
        th_off = $urandom_range(65535);
        dly    = $urandom_range(200);
        step   = $urandom_range(131071);
      end
      load_config(16'(th_on), 16'(th_off), 16'(dly), 17'(step));
      send_idle_pct = send_tab[seg / 2];
      stall_pct     = stall_tab[seg / 2];
      for (int n = 0; n < 230; n++) begin
        if (run_left == 0) begin
          kind     = level_kind_t'($urandom_range(4));
          run_left = $urandom_range(12, 1);
        end
        run_left--;
        case (kind)
          LVL_LOUD:     lvl = 16'($urandom_range(65535, th_on));
          LVL_QUIET:    lvl = 16'($urandom_range(th_off, 0));
          LVL_NEAR_ON:  lvl = 16'(th_on + $urandom_range(6) - 3);
          LVL_NEAR_OFF: lvl = 16'(th_off + $urandom_range(6) - 3);
          default:      lvl = 16'($urandom());
        endcase
        r = $urandom_range(99);
        if (r < 4)
          stamp = $urandom();
        else if (r < 7)
          stamp = stamp - $urandom_range(1000, 1);
        else
          stamp = stamp + $urandom_range(dly / 4 + 2);
        send_tick(lvl, stamp);
      end
      drain_results();
    end
  endtask

  // receiver holds off while words keep coming, so the input side must stall
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    for (int i = 0; i < 40; i++)
      send_tick(16'($urandom()), 32'd7000 + 32'($urandom_range(3)) + 32'(i * 20));
    drain_results();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_levels();
    test_special_settings();
    test_random_traffic();
    test_backpressure();
    drain_results();
    if (mismatch_count == 0)
      $display("tb_voice_activity_hysteresis_debounce_fade: done, clean");
    else
      $display("tb_voice_activity_hysteresis_debounce_fade: done, errors");
    $finish;
  end

endmodule
